### rtl/core/sha256c_pkg.sv
// Shared types, constants and round functions for the SHA-256 compression core.
// Depends on nothing; imported by the controller, the datapath and the top level.
`default_nettype none

package sha256c_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NUM_HASH   = 8;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned NUM_ROUNDS = 64;

    localparam logic [5:0] LAST_ROUND      = 6'd63;
    localparam logic [5:0] FIRST_EXT_ROUND = 6'd15;
    localparam logic [3:0] LAST_WORD       = 4'd15;
    localparam logic [2:0] LAST_DIGEST     = 3'd7;

    typedef struct packed {
        logic [31:0] msg_word;
        logic        start_message;
        logic        final_block;
    } t_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } t_resp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_word;
        logic       reload_iv;
        logic       init;
        logic       round;
        logic [5:0] round_idx;
        logic       sched_ext;
        logic       add;
        logic       emit;
        logic [2:0] emit_idx;
        logic       emit_last;
    } t_dp_cmd;

    localparam logic [31:0] IV_TABLE [NUM_HASH] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] K_TABLE [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sig0(input logic [31:0] v);
        return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] v);
        return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] v);
        return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] v);
        return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'd0, v[31:10]};
    endfunction

endpackage

`default_nettype wire

### rtl/core/sha256c_dp.sv
// Datapath of the SHA-256 compression core: schedule window, working variables,
// hash words and the digest output register. Depends on sha256c_pkg.
`default_nettype none

module sha256c_dp
    import sha256c_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [31:0] i_msg_word,
    output t_resp            o_resp
);

    // The window is a shift line: slot 0 always holds the oldest word.
    logic [31:0] r_w    [BLOCK_WORDS];
    logic [31:0] r_v    [NUM_HASH];
    logic [31:0] r_hash [NUM_HASH];
    logic [31:0] r_wr;
    t_resp       r_resp;

    logic [31:0] n_w_next;
    logic [31:0] n_t1;
    logic [31:0] n_t2;
    logic [31:0] n_ch;
    logic [31:0] n_maj;

    // Next schedule word, one round ahead of its use.
    always_comb begin
        if (i_cmd.sched_ext) begin
            n_w_next = small_sig1(r_w[14]) + r_w[9] + small_sig0(r_w[1]) + r_w[0];
        end else begin
            n_w_next = r_w[0];
        end
    end

    always_comb begin
        n_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        n_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        n_t1  = r_v[7] + big_sig1(r_v[4]) + n_ch + K_TABLE[i_cmd.round_idx] + r_wr;
        n_t2  = big_sig0(r_v[0]) + n_maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[BLOCK_WORDS - 1] <= i_msg_word;
        end else if (i_cmd.init || i_cmd.round) begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[BLOCK_WORDS - 1] <= n_w_next;
        end

        if (i_cmd.init) begin
            r_wr <= r_w[0];
            for (int k = 0; k < NUM_HASH; k++) begin
                r_v[k] <= r_hash[k];
            end
        end else if (i_cmd.round) begin
            r_wr   <= n_w_next;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + n_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= n_t1 + n_t2;
        end

        if (i_cmd.emit) begin
            r_resp.digest_word <= r_hash[i_cmd.emit_idx];
            r_resp.digest_last <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_HASH; k++) begin
                r_hash[k] <= IV_TABLE[k];
            end
        end else if (i_cmd.load_word && i_cmd.reload_iv) begin
            for (int k = 0; k < NUM_HASH; k++) begin
                r_hash[k] <= IV_TABLE[k];
            end
        end else if (i_cmd.add) begin
            for (int k = 0; k < NUM_HASH; k++) begin
                r_hash[k] <= r_hash[k] + r_v[k];
            end
        end
    end

    assign o_resp = r_resp;

endmodule

`default_nettype wire

### rtl/core/sha256c_ctrl.sv
// Controller of the SHA-256 compression core: word counting, round sequencing
// and digest emission. Depends on sha256c_pkg; drives sha256c_dp.
`default_nettype none

module sha256c_ctrl
    import sha256c_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_start_message,
    input  wire logic i_final_block,
    output logic      o_busy,
    output logic      o_strobe,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [3:0] r_word_cnt;
    logic [3:0] n_word_cnt;
    logic [5:0] r_round;
    logic [5:0] n_round;
    logic [2:0] r_out;
    logic [2:0] n_out;
    logic       r_final;
    logic       n_final;
    logic       r_strobe;
    logic       n_strobe;
    logic       w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_word_cnt = r_word_cnt;
        n_round    = r_round;
        n_out      = r_out;
        n_final    = r_final;
        n_strobe   = 1'b0;
        o_cmd      = '0;
        o_cmd.round_idx = r_round;
        o_cmd.emit_idx  = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_word = 1'b1;
                    o_cmd.reload_iv = (r_word_cnt == '0) && i_start_message;
                    n_word_cnt      = r_word_cnt + 4'd1;
                    if (r_word_cnt == LAST_WORD) begin
                        n_final = i_final_block;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_round    = '0;
                n_state    = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round     = 1'b1;
                o_cmd.sched_ext = (r_round >= FIRST_EXT_ROUND);
                n_round         = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_out     = '0;
                n_state   = r_final ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = (r_out == LAST_DIGEST);
                n_strobe        = 1'b1;
                n_out           = r_out + 3'd1;
                if (r_out == LAST_DIGEST) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_word_cnt <= '0;
            r_round    <= '0;
            r_out      <= '0;
            r_final    <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_word_cnt <= n_word_cnt;
            r_round    <= n_round;
            r_out      <= n_out;
            r_final    <= n_final;
            r_strobe   <= n_strobe;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    a_strobe_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_OUT))
        else $error("result strobe without a preceding emit cycle");

    a_init_to_round0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |=> (r_state == S_ROUND) && (r_round == '0))
        else $error("rounds did not start at round zero");

    a_last_round_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) && (r_round == LAST_ROUND) |=> (r_state == S_ADD))
        else $error("hash update did not follow the last round");

    a_block_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_word_cnt == '0))
        else $error("word count not at a block boundary while compressing");

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) && !r_final |=> (r_state == S_IDLE) && !r_strobe)
        else $error("digest emitted for a block not marked final");

endmodule

`default_nettype wire

### rtl/core/sha256_compression_core.sv
// After the sixteenth word of a block the controller runs a setup state (S_INIT),
// the 64 rounds (one round per cycle in the datapath) and a hash-update state
// (S_ADD); on a final block the eight digest words then follow on eight consecutive
// strobes, each registered from an S_OUT state.
// busy is low only while words of a block are being collected; results cannot stall.
// Reset (synchronous, active low) loads the initial hash and clears the word count.
`default_nettype none

module sha256_compression_core
    import sha256c_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_strobe,
    output t_resp     o_resp
);

    t_dp_cmd w_cmd;

    sha256c_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_start_message (i_req.start_message),
        .i_final_block   (i_req.final_block),
        .o_busy          (busy),
        .o_strobe        (o_strobe),
        .o_cmd           (w_cmd)
    );

    sha256c_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_msg_word (i_req.msg_word),
        .o_resp     (o_resp)
    );

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for sha256_compression_core: random message blocks
// in, digest words checked against an independent SHA-256 model kept in this file.
// Depends on sha256c_pkg for the request and response types and the block sizes.
`default_nettype none

module testbench;
    import sha256c_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 100;
    localparam int unsigned RAND_BLOCKS    = 13;
    localparam int unsigned CALM_BLOCKS    = 3;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        t_req       req;
        logic [3:0] gap;
        logic       drain;
    } t_feed_item;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_strobe;
    t_resp o_resp;

    t_feed_item feed_q[$];
    t_resp      digest_q[$];

    // Model state: chaining hash, the sixteen words of the block being collected, position.
    logic [31:0] chain_hash [8];
    logic [31:0] block_words [16];
    logic [3:0]  word_pos;

    int unsigned n_issued     = 0;
    int unsigned n_accepted   = 0;
    int unsigned n_blocks     = 0;
    int unsigned n_digests    = 0;
    int unsigned n_errors     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned idle_count   = 0;

    logic       next_start;
    t_req       next_req;
    t_feed_item head;
    t_resp      want;

    sha256_compression_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_resp   (o_resp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] rotr32(input logic [31:0] v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] sum0(input logic [31:0] v);
        return rotr32(v, 2) ^ rotr32(v, 13) ^ rotr32(v, 22);
    endfunction

    function automatic logic [31:0] sum1(input logic [31:0] v);
        return rotr32(v, 6) ^ rotr32(v, 11) ^ rotr32(v, 25);
    endfunction

    function automatic logic [31:0] gam0(input logic [31:0] v);
        return rotr32(v, 7) ^ rotr32(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] gam1(input logic [31:0] v);
        return rotr32(v, 17) ^ rotr32(v, 19) ^ (v >> 10);
    endfunction

    // Runs the 64 rounds over the collected block and folds the result into the chain.
    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wr;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < BLOCK_WORDS; i++) w[i] = block_words[i];
        for (int i = 0; i < NUM_HASH; i++) v[i] = chain_hash[i];
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            if (r < BLOCK_WORDS) begin
                wr = w[r];
            end else begin
                wr = gam1(w[(r - 2) % 16]) + w[(r - 7) % 16] + gam0(w[(r - 15) % 16])
                   + w[r % 16];
                w[r % 16] = wr;
            end
            t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
            t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < NUM_HASH; i++) chain_hash[i] = chain_hash[i] + v[i];
    endtask

    task automatic absorb_word(input t_req r);
        t_resp d;
        // The start flag only counts on the first word, the final flag only on the last.
        if (word_pos == '0 && r.start_message) begin
            for (int i = 0; i < NUM_HASH; i++) chain_hash[i] = SHA_IV[i];
        end
        block_words[word_pos] = r.msg_word;
        if (word_pos != LAST_WORD) begin
            word_pos = word_pos + 1'b1;
        end else begin
            word_pos = '0;
            n_blocks++;
            compress_block();
            if (r.final_block) begin
                n_digests++;
                for (int i = 0; i < NUM_HASH; i++) begin
                    d.digest_word = chain_hash[i];
                    d.digest_last = (i == LAST_DIGEST);
                    digest_q.push_back(d);
                end
            end
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_word(input t_req r, input bit drain, input bit calm);
        t_feed_item f;
        f.req   = r;
        f.drain = drain;
        f.gap   = (!calm && $urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 11)) : 4'd0;
        feed_q.push_back(f);
    endtask

    // Request driver: presents the next queued word at the falling edge and holds it
    // until the core takes it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_count = 0;
        end else if (!start || n_accepted == n_issued) begin
            next_start = 1'b0;
            next_req.msg_word      = $urandom;
            next_req.start_message = 1'($urandom_range(0, 1));
            next_req.final_block   = 1'($urandom_range(0, 1));
            if (feed_q.size() != 0) begin
                if (idle_count < feed_q[0].gap) begin
                    idle_count++;
                end else if (!(feed_q[0].drain && digest_q.size() != 0)) begin
                    head       = feed_q.pop_front();
                    next_start = 1'b1;
                    next_req   = head.req;
                    n_issued++;
                    idle_count = 0;
                end
            end
            start <= next_start;
            i_req <= next_req;
        end
    end

    // Monitor: models every accepted request and checks every digest strobe.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_HASH; i++) chain_hash[i] = SHA_IV[i];
            for (int i = 0; i < BLOCK_WORDS; i++) block_words[i] = '0;
            word_pos     = '0;
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (start && !busy) begin
                absorb_word(i_req);
                n_accepted++;
                quiet_cycles = 0;
            end
            if (o_strobe) begin
                quiet_cycles = 0;
                if (digest_q.size() == 0) begin
                    $error("unexpected digest strobe: digest_word %h digest_last %b",
                           o_resp.digest_word, o_resp.digest_last);
                    n_errors++;
                end else begin
                    want = digest_q.pop_front();
                    if (o_resp.digest_word !== want.digest_word) begin
                        $error("digest_word: expected %h, got %h",
                               want.digest_word, o_resp.digest_word);
                        n_errors++;
                    end
                    if (o_resp.digest_last !== want.digest_last) begin
                        $error("digest_last: expected %b, got %b",
                               want.digest_last, o_resp.digest_last);
                        n_errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no activity for %0d cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        t_req r;
        bit   blk_start;
        bit   blk_final;
        bit   calm;

        // Opening block: all-ones and all-zero words, with stray start and final flags
        // on inner words that the core must ignore.
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            r.msg_word      = (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
            r.start_message = (i == 0 || i == 3 || i == 7);
            r.final_block   = (i == 5 || i == 9 || i == LAST_WORD);
            push_word(r, 1'b0, 1'b0);
        end

        for (int b = 0; b < RAND_BLOCKS; b++) begin
            blk_start = (b == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            // The blocks ahead of the held-back ones always end with a digest.
            blk_final = (b == RAND_BLOCKS - 1 || b == 1 || b == 6) ? 1'b1 :
                        ($urandom_range(0, 2) != 0);
            calm      = (b >= RAND_BLOCKS - CALM_BLOCKS) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                r.msg_word      = pick_word();
                r.start_message = (i == 0) ? blk_start : 1'($urandom_range(0, 1));
                r.final_block   = (i == LAST_WORD) ? blk_final : 1'($urandom_range(0, 1));
                // Hold the request back until all digests so far are out.
                push_word(r, (i == 0) && (b == 2 || b == 7), calm);
            end
        end

        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        do @(posedge i_clk);
        while (feed_q.size() != 0 || n_accepted != n_issued || digest_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d message words forming %0d blocks", n_accepted, n_blocks);
        $display("checked %0d digests of eight words, %0d mismatches", n_digests, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
